FILE: sv/mepg_pkg.sv
// Shared types and constants of the midpoint ellipse point generator.
// Holds the sequencer states, the micro-operation format of the shared
// multiplier and the table of micro-operation programs. No dependencies.
package mepg_pkg;

    // Operation codes carried by the operation field of a request.
    localparam logic OPER_START   = 1'b0;
    localparam logic OPER_ADVANCE = 1'b1;

    // Width of the step counter inside one program.
    localparam int STEP_BITS = 3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_NEXT,
        S_EMIT,
        S_MOVE
    } state_t;

    // Micro-operation programs of the sequencer.
    typedef enum logic [2:0] {
        P_START,
        P_TEST,
        P_SWITCH,
        P_R1_FLAT,
        P_R1_DIAG,
        P_R2_VERT,
        P_R2_DIAG
    } prog_t;

    // Multiplier operand sources.
    typedef enum logic [3:0] {
        OP_ONE,
        OP_X,
        OP_Y,
        OP_RX,
        OP_RY,
        OP_RX2,
        OP_RY2,
        OP_T,
        OP_YM,
        OP_TMP
    } opnd_t;

    // Scaling applied to a product before it is written back.
    typedef enum logic [2:0] {
        SH_NONE,
        SH_L1,
        SH_L2,
        SH_L3,
        SH_R2
    } shift_t;

    // Write-back destinations and accumulate modes.
    typedef enum logic [2:0] {
        WB_RX2,
        WB_RY2,
        WB_TMP,
        WB_DEC_SET,
        WB_DEC_ADD,
        WB_DEC_SUB,
        WB_SCR_SET,
        WB_SCR_SUB
    } wb_t;

    // One micro-operation of the shared multiplier.
    typedef struct packed {
        opnd_t  a;
        opnd_t  b;
        shift_t sh;
        wb_t    wb;
    } uop_t;

    // Status of the accumulators seen by the sequencer.
    typedef struct packed {
        logic dec_neg;
        logic dec_zero;
        logic scr_neg;
    } mepg_flags_t;

    // Controls from the sequencer to the holding and output registers.
    typedef struct packed {
        logic load_held;
        logic load_out;
        logic region;
        logic last;
    } mepg_ctrl_t;

    // Index of the final step of each program.
    function automatic logic [STEP_BITS-1:0] prog_last(prog_t p);
        logic [STEP_BITS-1:0] n;
        case (p)
            P_START:   n = STEP_BITS'(4);
            P_TEST:    n = STEP_BITS'(1);
            P_SWITCH:  n = STEP_BITS'(4);
            P_R1_FLAT: n = STEP_BITS'(1);
            P_R1_DIAG: n = STEP_BITS'(2);
            P_R2_VERT: n = STEP_BITS'(1);
            P_R2_DIAG: n = STEP_BITS'(2);
            default:   n = STEP_BITS'(0);
        endcase
        return n;
    endfunction

    // Micro-operation table. Each entry is operand a times operand b,
    // scaled, then written to its destination.
    function automatic uop_t prog_uop(prog_t p, logic [STEP_BITS-1:0] step);
        uop_t u;
        u = '{a: OP_ONE, b: OP_ONE, sh: SH_NONE, wb: WB_TMP};
        case (p)
            // Squares of the radii, then ry^2 - rx^2*ry + rx^2/4.
            P_START:
            begin
                case (step)
                    3'd0:    u = '{a: OP_RX,  b: OP_RX,  sh: SH_NONE, wb: WB_RX2};
                    3'd1:    u = '{a: OP_RY,  b: OP_RY,  sh: SH_NONE, wb: WB_RY2};
                    3'd2:    u = '{a: OP_RY2, b: OP_ONE, sh: SH_NONE, wb: WB_DEC_SET};
                    3'd3:    u = '{a: OP_RX2, b: OP_Y,   sh: SH_NONE, wb: WB_DEC_SUB};
                    default: u = '{a: OP_RX2, b: OP_ONE, sh: SH_R2,   wb: WB_DEC_ADD};
                endcase
            end
            // Region test: ry^2*x - rx^2*y.
            P_TEST:
            begin
                case (step)
                    3'd0:    u = '{a: OP_RY2, b: OP_X, sh: SH_NONE, wb: WB_SCR_SET};
                    default: u = '{a: OP_RX2, b: OP_Y, sh: SH_NONE, wb: WB_SCR_SUB};
                endcase
            end
            // Region-2 start: ry^2*t^2 + 4*rx^2*(y-1)^2 - 4*rx^2*ry^2.
            P_SWITCH:
            begin
                case (step)
                    3'd0:    u = '{a: OP_T,   b: OP_T,   sh: SH_NONE, wb: WB_TMP};
                    3'd1:    u = '{a: OP_RY2, b: OP_TMP, sh: SH_NONE, wb: WB_DEC_SET};
                    3'd2:    u = '{a: OP_YM,  b: OP_YM,  sh: SH_NONE, wb: WB_TMP};
                    3'd3:    u = '{a: OP_RX2, b: OP_TMP, sh: SH_L2,   wb: WB_DEC_ADD};
                    default: u = '{a: OP_RX2, b: OP_RY2, sh: SH_L2,   wb: WB_DEC_SUB};
                endcase
            end
            // Region 1, x step only: + 2*ry^2*x + ry^2.
            P_R1_FLAT:
            begin
                case (step)
                    3'd0:    u = '{a: OP_RY2, b: OP_X,   sh: SH_L1,   wb: WB_DEC_ADD};
                    default: u = '{a: OP_RY2, b: OP_ONE, sh: SH_NONE, wb: WB_DEC_ADD};
                endcase
            end
            // Region 1, diagonal step: + 2*ry^2*x + ry^2 - 2*rx^2*y.
            P_R1_DIAG:
            begin
                case (step)
                    3'd0:    u = '{a: OP_RY2, b: OP_X,   sh: SH_L1,   wb: WB_DEC_ADD};
                    3'd1:    u = '{a: OP_RY2, b: OP_ONE, sh: SH_NONE, wb: WB_DEC_ADD};
                    default: u = '{a: OP_RX2, b: OP_Y,   sh: SH_L1,   wb: WB_DEC_SUB};
                endcase
            end
            // Region 2, y step only: + 4*rx^2 - 8*rx^2*y.
            P_R2_VERT:
            begin
                case (step)
                    3'd0:    u = '{a: OP_RX2, b: OP_ONE, sh: SH_L2, wb: WB_DEC_ADD};
                    default: u = '{a: OP_RX2, b: OP_Y,   sh: SH_L3, wb: WB_DEC_SUB};
                endcase
            end
            // Region 2, diagonal step: + 8*ry^2*x - 8*rx^2*y + 4*rx^2.
            P_R2_DIAG:
            begin
                case (step)
                    3'd0:    u = '{a: OP_RY2, b: OP_X,   sh: SH_L3, wb: WB_DEC_ADD};
                    3'd1:    u = '{a: OP_RX2, b: OP_Y,   sh: SH_L3, wb: WB_DEC_SUB};
                    default: u = '{a: OP_RX2, b: OP_ONE, sh: SH_L2, wb: WB_DEC_ADD};
                endcase
            end
            default:
            begin
                u = '{a: OP_ONE, b: OP_ONE, sh: SH_NONE, wb: WB_TMP};
            end
        endcase
        return u;
    endfunction

endpackage

FILE: sv/mepg_mac.sv
// Shared multiply-accumulate unit of the midpoint ellipse point generator.
// Holds the radius squares, a scratch operand, the decision value and the
// region test value. Depends on mepg_pkg.
module mepg_mac #(
    parameter int RADIUS_BITS = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      issue,
    input  mepg_pkg::uop_t            uop,
    input  logic [RADIUS_BITS-1:0]    offset_x,
    input  logic [RADIUS_BITS-1:0]    offset_y,
    input  logic [RADIUS_BITS-1:0]    radius_x,
    input  logic [RADIUS_BITS-1:0]    radius_y,
    output mepg_pkg::mepg_flags_t     flags
);
    import mepg_pkg::*;

    localparam int OPW = 2 * RADIUS_BITS + 2;
    localparam int DW  = 2 * OPW;

    logic [OPW-1:0] rx2_reg;
    logic [OPW-1:0] ry2_reg;
    logic [OPW-1:0] tmp_reg;
    logic [DW-1:0]  dec_reg;
    logic [DW-1:0]  scr_reg;
    logic [DW-1:0]  prod_reg;
    uop_t           wb_uop_reg;
    logic           wb_valid_reg;

    logic [RADIUS_BITS-1:0] ym;
    logic [OPW-1:0]         opa;
    logic [OPW-1:0]         opb;
    logic [DW-1:0]          term;
    logic [DW-1:0]          base;
    logic [DW-1:0]          sum;

    // Distance of y-1 from zero; y = 0 squares to the same value as y = 2.
    assign ym = (offset_y == '0) ? RADIUS_BITS'(1) : offset_y - RADIUS_BITS'(1);

    // Operand selection for both multiplier inputs.
    always_comb
    begin
        case (uop.a)
            OP_ONE:  opa = OPW'(1);
            OP_X:    opa = {{(OPW-RADIUS_BITS){1'b0}}, offset_x};
            OP_Y:    opa = {{(OPW-RADIUS_BITS){1'b0}}, offset_y};
            OP_RX:   opa = {{(OPW-RADIUS_BITS){1'b0}}, radius_x};
            OP_RY:   opa = {{(OPW-RADIUS_BITS){1'b0}}, radius_y};
            OP_RX2:  opa = rx2_reg;
            OP_RY2:  opa = ry2_reg;
            OP_T:    opa = {{(OPW-RADIUS_BITS-1){1'b0}}, offset_x, 1'b1};
            OP_YM:   opa = {{(OPW-RADIUS_BITS){1'b0}}, ym};
            OP_TMP:  opa = tmp_reg;
            default: opa = '0;
        endcase
    end

    always_comb
    begin
        case (uop.b)
            OP_ONE:  opb = OPW'(1);
            OP_X:    opb = {{(OPW-RADIUS_BITS){1'b0}}, offset_x};
            OP_Y:    opb = {{(OPW-RADIUS_BITS){1'b0}}, offset_y};
            OP_RX:   opb = {{(OPW-RADIUS_BITS){1'b0}}, radius_x};
            OP_RY:   opb = {{(OPW-RADIUS_BITS){1'b0}}, radius_y};
            OP_RX2:  opb = rx2_reg;
            OP_RY2:  opb = ry2_reg;
            OP_T:    opb = {{(OPW-RADIUS_BITS-1){1'b0}}, offset_x, 1'b1};
            OP_YM:   opb = {{(OPW-RADIUS_BITS){1'b0}}, ym};
            OP_TMP:  opb = tmp_reg;
            default: opb = '0;
        endcase
    end

    // Multiplier stage: the product and its write-back control are registered.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg   <= {{OPW{1'b0}}, opa} * {{OPW{1'b0}}, opb};
            wb_uop_reg <= uop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= issue;
        end
    end

    // Scaling of the registered product.
    always_comb
    begin
        case (wb_uop_reg.sh)
            SH_NONE: term = prod_reg;
            SH_L1:   term = {prod_reg[DW-2:0], 1'b0};
            SH_L2:   term = {prod_reg[DW-3:0], 2'b00};
            SH_L3:   term = {prod_reg[DW-4:0], 3'b000};
            SH_R2:   term = {2'b00, prod_reg[DW-1:2]};
            default: term = prod_reg;
        endcase
    end

    // One adder serves both accumulators; a set starts from zero.
    always_comb
    begin
        case (wb_uop_reg.wb)
            WB_DEC_ADD, WB_DEC_SUB: base = dec_reg;
            WB_SCR_SUB:             base = scr_reg;
            default:                base = '0;
        endcase
        if (wb_uop_reg.wb == WB_DEC_SUB || wb_uop_reg.wb == WB_SCR_SUB)
        begin
            sum = base - term;
        end
        else
        begin
            sum = base + term;
        end
    end

    // Write-back stage.
    always_ff @(posedge clk)
    begin
        if (wb_valid_reg)
        begin
            case (wb_uop_reg.wb)
                WB_RX2:  rx2_reg <= term[OPW-1:0];
                WB_RY2:  ry2_reg <= term[OPW-1:0];
                WB_TMP:  tmp_reg <= term[OPW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg <= '0;
            scr_reg <= '0;
        end
        else if (wb_valid_reg)
        begin
            case (wb_uop_reg.wb)
                WB_DEC_SET, WB_DEC_ADD, WB_DEC_SUB: dec_reg <= sum;
                WB_SCR_SET, WB_SCR_SUB:             scr_reg <= sum;
                default:                            ;
            endcase
        end
    end

    assign flags.dec_neg  = dec_reg[DW-1];
    assign flags.dec_zero = (dec_reg == '0);
    assign flags.scr_neg  = scr_reg[DW-1];

endmodule

FILE: sv/mepg_seq.sv
// Sequencer of the midpoint ellipse point generator: request handshake,
// current offsets, region and the micro-operation programs fed to the
// shared multiplier. Depends on mepg_pkg.
module mepg_seq #(
    parameter int RADIUS_BITS = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      operation,
    input  logic [RADIUS_BITS-1:0]    radius_y,
    input  logic                      out_free,
    input  mepg_pkg::mepg_flags_t     flags,
    output logic                      issue,
    output mepg_pkg::uop_t            uop,
    output logic [RADIUS_BITS-1:0]    offset_x,
    output logic [RADIUS_BITS-1:0]    offset_y,
    output mepg_pkg::mepg_ctrl_t      ctrl
);
    import mepg_pkg::*;

    state_t                 state_reg, state_next;
    prog_t                  prog_reg, prog_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic                   phase_reg, phase_next;
    logic [RADIUS_BITS-1:0] x_reg, x_next;
    logic [RADIUS_BITS-1:0] y_reg, y_next;
    logic                   region_reg, region_next;
    logic                   active_reg, active_next;
    logic                   accept;
    logic                   is_last;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign is_last  = region_reg && (y_reg == '0);
    assign offset_x = x_reg;
    assign offset_y = y_reg;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            prog_reg   <= P_START;
            step_reg   <= '0;
            phase_reg  <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            region_reg <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            prog_reg   <= prog_next;
            step_reg   <= step_next;
            phase_reg  <= phase_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            region_reg <= region_next;
            active_reg <= active_next;
        end
    end

    // Next state and outputs.
    always_comb
    begin
        state_next  = state_reg;
        prog_next   = prog_reg;
        step_next   = step_reg;
        phase_next  = phase_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        region_next = region_reg;
        active_next = active_reg;
        issue       = 1'b0;
        uop         = prog_uop(prog_reg, step_reg);
        ctrl        = '{load_held: 1'b0, load_out: 1'b0, region: region_reg,
                        last: is_last};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OPER_START)
                    begin
                        ctrl.load_held = 1'b1;
                        x_next         = '0;
                        y_next         = radius_y;
                        region_next    = 1'b0;
                        prog_next      = P_START;
                        step_next      = '0;
                        phase_next     = 1'b0;
                        state_next     = S_RUN;
                    end
                    else if (active_reg)
                    begin
                        if (region_reg)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            prog_next  = P_TEST;
                            step_next  = '0;
                            phase_next = 1'b0;
                            state_next = S_RUN;
                        end
                    end
                end
            end

            // Issue a product, then wait while it is written back before the next step.
            S_RUN:
            begin
                if (!phase_reg)
                begin
                    issue      = 1'b1;
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    if (step_reg == prog_last(prog_reg))
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        step_next = step_reg + STEP_BITS'(1);
                    end
                end
            end

            // Act on the finished program.
            S_NEXT:
            begin
                case (prog_reg)
                    P_START:
                    begin
                        active_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    P_TEST:
                    begin
                        if (!flags.scr_neg)
                        begin
                            prog_next  = P_SWITCH;
                            step_next  = '0;
                            state_next = S_RUN;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    P_SWITCH:
                    begin
                        region_next = 1'b1;
                        state_next  = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // Hand the current point to the output register.
            S_EMIT:
            begin
                if (out_free)
                begin
                    ctrl.load_out = 1'b1;
                    if (is_last)
                    begin
                        active_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MOVE;
                    end
                end
            end

            // Step the offsets and pick the decision update.
            S_MOVE:
            begin
                step_next  = '0;
                phase_next = 1'b0;
                state_next = S_RUN;
                if (!region_reg)
                begin
                    x_next = x_reg + RADIUS_BITS'(1);
                    if (flags.dec_neg)
                    begin
                        prog_next = P_R1_FLAT;
                    end
                    else
                    begin
                        y_next    = y_reg - RADIUS_BITS'(1);
                        prog_next = P_R1_DIAG;
                    end
                end
                else if (!flags.dec_neg && !flags.dec_zero)
                begin
                    y_next    = y_reg - RADIUS_BITS'(1);
                    prog_next = P_R2_VERT;
                end
                else
                begin
                    x_next    = x_reg + RADIUS_BITS'(1);
                    y_next    = y_reg - RADIUS_BITS'(1);
                    prog_next = P_R2_DIAG;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A result is never written over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> out_free)
        else $error("point loaded while output is occupied");

    // Each product gets its write-back cycle before the next one issues.
    assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> !issue)
        else $error("back-to-back issue to the shared multiplier");

    // The final point ends the ellipse.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load_out && ctrl.last) |=> !active_reg)
        else $error("ellipse still active after its last point");

    // Offsets only move while an ellipse is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |-> active_reg)
        else $error("offset step without an active ellipse");

endmodule

FILE: sv/midpoint_ellipse_point_generator_top.sv
// A start request captures the radii and centre, sets up the radius squares and the
// decision value and gives no result. An advance registers the current point, waiting
// while the output is stalled. No new request is taken until the sequencer is idle
// again; an advance with no ellipse gives no result. The shared multiplier takes a new
// product only after the last is written back. Reset (rst_n, asynchronous, active low)
// leaves the block idle. Depends on mepg_pkg, mepg_mac and mepg_seq.
module midpoint_ellipse_point_generator_top #(
    parameter int RADIUS_BITS = 11,
    parameter int COORD_BITS  = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [RADIUS_BITS-1:0]        radius_x,
    input  logic [RADIUS_BITS-1:0]        radius_y,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_BITS+1:0]  col_plus,
    output logic signed [COORD_BITS+1:0]  col_minus,
    output logic signed [COORD_BITS+1:0]  row_plus,
    output logic signed [COORD_BITS+1:0]  row_minus,
    output logic                          region,
    output logic                          last
);
    import mepg_pkg::*;

    localparam int OUTW = COORD_BITS + 2;
    localparam int SUMW = ((RADIUS_BITS > COORD_BITS) ? RADIUS_BITS : COORD_BITS) + 2;

    logic [RADIUS_BITS-1:0] held_rx_reg;
    logic [RADIUS_BITS-1:0] held_ry_reg;
    logic [COORD_BITS-1:0]  held_cx_reg;
    logic [COORD_BITS-1:0]  held_cy_reg;
    logic                   out_valid_reg;
    logic [OUTW-1:0]        col_plus_reg;
    logic [OUTW-1:0]        col_minus_reg;
    logic [OUTW-1:0]        row_plus_reg;
    logic [OUTW-1:0]        row_minus_reg;
    logic                   region_reg;
    logic                   last_reg;

    logic                   out_free;
    logic                   issue;
    uop_t                   uop;
    mepg_flags_t            flags;
    mepg_ctrl_t             ctrl;
    logic [RADIUS_BITS-1:0] offset_x;
    logic [RADIUS_BITS-1:0] offset_y;
    logic [SUMW-1:0]        cx_ext;
    logic [SUMW-1:0]        cy_ext;
    logic [SUMW-1:0]        x_ext;
    logic [SUMW-1:0]        y_ext;
    logic [SUMW-1:0]        cp_sum;
    logic [SUMW-1:0]        cm_sum;
    logic [SUMW-1:0]        rp_sum;
    logic [SUMW-1:0]        rm_sum;

    mepg_seq #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .radius_y  (radius_y),
        .out_free  (out_free),
        .flags     (flags),
        .issue     (issue),
        .uop       (uop),
        .offset_x  (offset_x),
        .offset_y  (offset_y),
        .ctrl      (ctrl)
    );

    mepg_mac #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue),
        .uop      (uop),
        .offset_x (offset_x),
        .offset_y (offset_y),
        .radius_x (held_rx_reg),
        .radius_y (held_ry_reg),
        .flags    (flags)
    );

    // Radii and centre captured by a start request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_rx_reg <= '0;
            held_ry_reg <= '0;
            held_cx_reg <= '0;
            held_cy_reg <= '0;
        end
        else if (ctrl.load_held)
        begin
            held_rx_reg <= radius_x;
            held_ry_reg <= radius_y;
            held_cx_reg <= center_x;
            held_cy_reg <= center_y;
        end
    end

    // Mirrored coordinates, wrapped to the output width.
    assign cx_ext = {{(SUMW-COORD_BITS){1'b0}}, held_cx_reg};
    assign cy_ext = {{(SUMW-COORD_BITS){1'b0}}, held_cy_reg};
    assign x_ext  = {{(SUMW-RADIUS_BITS){1'b0}}, offset_x};
    assign y_ext  = {{(SUMW-RADIUS_BITS){1'b0}}, offset_y};
    assign cp_sum = cx_ext + x_ext;
    assign cm_sum = cx_ext - x_ext;
    assign rp_sum = cy_ext + y_ext;
    assign rm_sum = cy_ext - y_ext;

    // Output register; it frees up in the cycle its request is taken.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            col_plus_reg  <= cp_sum[OUTW-1:0];
            col_minus_reg <= cm_sum[OUTW-1:0];
            row_plus_reg  <= rp_sum[OUTW-1:0];
            row_minus_reg <= rm_sum[OUTW-1:0];
            region_reg    <= ctrl.region;
            last_reg      <= ctrl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign col_plus  = col_plus_reg;
    assign col_minus = col_minus_reg;
    assign row_plus  = row_plus_reg;
    assign row_minus = row_minus_reg;
    assign region    = region_reg;
    assign last      = last_reg;

endmodule
